/* rtl/dlf_pkg.sv */
package dlf_pkg;

    // Request codes of an input word.
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_INPUT  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_INPUTS  = 2'd1;
    localparam logic [1:0] CFG_NEURONS = 2'd2;

    // Activation modes.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_RELU    = 3'd1;
    localparam logic [2:0] ACT_LEAKY   = 3'd2;
    localparam logic [2:0] ACT_ELU     = 3'd3;
    localparam logic [2:0] ACT_SOFTMAX = 3'd4;

    localparam int FRAC_BITS = 12;
    localparam int EXP_WIDTH = 34;
    localparam int SUM_WIDTH = 40;
    localparam int PRE_WIDTH = 32;

    localparam logic signed [17:0] LOG2E_Q16  = 18'sd94548;
    localparam logic signed [6:0]  LEAK_SLOPE = 7'sd41;
    localparam logic [EXP_WIDTH-1:0] EXP_MAX  = {EXP_WIDTH{1'b1}};

    typedef logic signed [PRE_WIDTH-1:0] pre_t;
    typedef logic [EXP_WIDTH-1:0] exp_t;

    // Handshake between the top level and the exponential unit.
    typedef struct packed {
        logic start;
        pre_t x;
    } exp_req_t;

    typedef struct packed {
        logic done;
        exp_t result;
    } exp_rsp_t;

    // 2^(j/16) in Q.16 for j = 0 to 16.
    function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
        logic [17:0] r;
        case (idx)
            5'd0:    r = 18'd65536;
            5'd1:    r = 18'd68438;
            5'd2:    r = 18'd71468;
            5'd3:    r = 18'd74632;
            5'd4:    r = 18'd77936;
            5'd5:    r = 18'd81386;
            5'd6:    r = 18'd84990;
            5'd7:    r = 18'd88752;
            5'd8:    r = 18'd92682;
            5'd9:    r = 18'd96785;
            5'd10:   r = 18'd101070;
            5'd11:   r = 18'd105545;
            5'd12:   r = 18'd110218;
            5'd13:   r = 18'd115098;
            5'd14:   r = 18'd120194;
            5'd15:   r = 18'd125515;
            5'd16:   r = 18'd131072;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

/* rtl/dlf_if.sv */
interface dlf_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [5:0]                   input_index;
    logic [5:0]                   neuron_index;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_element;

    modport source (output valid, req_type, input_index, neuron_index, value, last_element,
                    input ready);
    modport sink (input valid, req_type, input_index, neuron_index, value, last_element,
                  output ready);
endinterface

interface dlf_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [5:0]                   out_neuron;
    logic signed [DATA_WIDTH-1:0] activation;
    logic                         saturated;
    logic                         last_result;

    modport source (output valid, out_neuron, activation, saturated, last_result,
                    input ready);
    modport sink (input valid, out_neuron, activation, saturated, last_result,
                  output ready);
endinterface

/* rtl/dlf_exp.sv */
module dlf_exp (
    input  logic              clk,
    input  logic              rst_n,
    input  dlf_pkg::exp_req_t req,
    output dlf_pkg::exp_rsp_t rsp
);
    import dlf_pkg::*;

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic signed [49:0]  prod_reg;
    logic [17:0]         m_reg;
    logic signed [5:0]   k_reg;
    logic                big_reg;
    logic                zero_reg;
    exp_t                res_reg;

    logic signed [33:0]  y;
    logic signed [21:0]  k;
    logic [3:0]          j;
    logic [7:0]          rem;
    logic [17:0]         t0;
    logic [17:0]         t1;
    logic [20:0]         step;
    logic [17:0]         m_next;
    logic [35:0]         shifted;
    logic [4:0]          sh;

    // Valid pipeline, three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Exponent split and table interpolation.
    always_comb
    begin
        y      = prod_reg[49:16];
        k      = y[33:12];
        j      = y[11:8];
        rem    = y[7:0];
        t0     = pow2_frac({1'b0, j});
        t1     = pow2_frac(5'({1'b0, j}) + 5'd1);
        step   = 21'((t1 - t0) * rem);
        m_next = t0 + 18'(step >> 8);
    end

    // Final shift by the integer exponent.
    always_comb
    begin
        if (k_reg >= 6'sd4)
        begin
            sh      = 5'(k_reg - 6'sd4);
            shifted = 36'(m_reg) << sh;
        end
        else
        begin
            sh      = 5'(6'sd4 - k_reg);
            shifted = 36'(m_reg) >> sh;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 50'(req.x * LOG2E_Q16);
        m_reg    <= m_next;
        k_reg    <= k[5:0];
        big_reg  <= k > 22'sd21;
        zero_reg <= k < -22'sd13;
        if (big_reg)
        begin
            res_reg <= EXP_MAX;
        end
        else if (zero_reg)
        begin
            res_reg <= '0;
        end
        else if (shifted > 36'(EXP_MAX))
        begin
            res_reg <= EXP_MAX;
        end
        else
        begin
            res_reg <= shifted[EXP_WIDTH-1:0];
        end
    end

    assign rsp.done   = v3_reg;
    assign rsp.result = res_reg;

endmodule

/* rtl/dense_layer_forward_core.sv */
// Dense layer with activation. Weight and bias words fill on-chip memories and are taken
// one per cycle; input-element words fill the input memory, and the element marked last
// starts a vector. The core then runs one multiply-accumulate per cycle out of the weight
// memory. Each neuron's accumulation pass also has the bias fetch, the pipeline drain and
// the rounding, and its output pass the memory read, the three-stage exponential unit, the
// activation and the output word. Softmax adds an exponential sum per neuron and, when the
// sum is nonzero, replaces the activation with a bit-serial division. No input word is
// taken while a vector is in progress. Results leave in neuron order, the final one marked
// last_result.
module dense_layer_forward_core #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_NEURONS = 64,
    parameter int DATA_WIDTH  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    dlf_in_if.sink     in_word,
    dlf_out_if.source  out_word
);
    import dlf_pkg::*;

    localparam int IAW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NAW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int WDEPTH = MAX_INPUTS * MAX_NEURONS;
    localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int ICW = $clog2(MAX_INPUTS + 1);
    localparam int NCW = $clog2(MAX_NEURONS + 1);
    localparam int AW = 2 * DATA_WIDTH + ICW + 14;
    localparam int NUMW = 48;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BIAS_RD = 4'd1;
    localparam logic [3:0] S_BIAS_LD = 4'd2;
    localparam logic [3:0] S_MAC     = 4'd3;
    localparam logic [3:0] S_DRAIN   = 4'd4;
    localparam logic [3:0] S_FINAL   = 4'd5;
    localparam logic [3:0] S_SUM     = 4'd6;
    localparam logic [3:0] S_OUT_RD  = 4'd7;
    localparam logic [3:0] S_OUT_LD  = 4'd8;
    localparam logic [3:0] S_OUT_EXP = 4'd9;
    localparam logic [3:0] S_ACT     = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_SEND    = 4'd12;

    // Memories.
    logic signed [DATA_WIDTH-1:0] input_mem [MAX_INPUTS];
    logic signed [DATA_WIDTH-1:0] weight_mem [WDEPTH];
    logic signed [DATA_WIDTH-1:0] bias_mem [MAX_NEURONS];
    pre_t                         pre_mem [MAX_NEURONS];

    logic signed [DATA_WIDTH-1:0] in_q;
    logic signed [DATA_WIDTH-1:0] w_q;
    logic signed [DATA_WIDTH-1:0] bias_q;
    pre_t                         pre_q;

    // Control and data registers.
    logic [3:0]                     state_reg;
    logic [2:0]                     mode_reg;
    logic [6:0]                     icount_reg;
    logic [6:0]                     ncount_reg;
    logic [ICW-1:0]                 icnt_reg;
    logic [NCW-1:0]                 ncnt_reg;
    logic [WAW:0]                   waddr_reg;
    logic                           rd_v_reg;
    logic                           mul_v_reg;
    logic signed [2*DATA_WIDTH-1:0] mul_reg;
    logic signed [AW-1:0]           acc_reg;
    logic [SUM_WIDTH-1:0]           sum_reg;
    pre_t                           x_reg;
    exp_t                           e_reg;
    logic [NUMW-1:0]                num_reg;
    logic [SUM_WIDTH:0]             rem_reg;
    logic [NUMW-1:0]                quo_reg;
    logic [5:0]                     div_cnt_reg;
    logic signed [DATA_WIDTH-1:0]   a_reg;
    logic                           sat_reg;
    logic                           out_valid_reg;
    logic [5:0]                     out_neuron_reg;
    logic signed [DATA_WIDTH-1:0]   out_act_reg;
    logic                           out_sat_reg;
    logic                           out_last_reg;

    logic             in_fire;
    logic [31:0]      in_addr_full;
    logic [31:0]      w_addr_full;
    logic [ICW-1:0]   nin;
    logic [NCW-1:0]   nn;
    logic             issue;
    logic signed [AW:0] rounded;
    logic signed [AW:0] shifted_acc;
    pre_t             p;
    exp_req_t         ereq;
    exp_rsp_t         ersp;
    logic signed [39:0] leak;
    logic signed [40:0] v;
    logic signed [DATA_WIDTH-1:0] v_clip;
    logic             v_sat;
    logic [SUM_WIDTH:0] rem_shift;
    logic             out_free;
    logic             last_n;

    assign in_fire = in_word.valid && in_word.ready;
    assign in_word.ready = (state_reg == S_IDLE);
    assign in_addr_full = 32'(in_word.input_index);
    assign w_addr_full = 32'(in_word.input_index) * 32'(MAX_NEURONS)
                         + 32'(in_word.neuron_index);

    // Counts are limited to the memory depths.
    assign nin = (32'(icount_reg) > 32'(MAX_INPUTS)) ? ICW'(MAX_INPUTS) : ICW'(icount_reg);
    assign nn = (32'(ncount_reg) > 32'(MAX_NEURONS)) ? NCW'(MAX_NEURONS) : NCW'(ncount_reg);
    assign issue = (state_reg == S_MAC) && (icnt_reg < nin);
    assign last_n = (ncnt_reg + NCW'(1)) == nn;

    // Input memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_word.req_type == REQ_INPUT && in_addr_full < 32'(MAX_INPUTS))
        begin
            input_mem[in_addr_full[IAW-1:0]] <= in_word.value;
        end
        in_q <= input_mem[icnt_reg[IAW-1:0]];
    end

    // Weight memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_word.req_type == REQ_WEIGHT
            && 32'(in_word.input_index) < 32'(MAX_INPUTS)
            && 32'(in_word.neuron_index) < 32'(MAX_NEURONS))
        begin
            weight_mem[w_addr_full[WAW-1:0]] <= in_word.value;
        end
        w_q <= weight_mem[waddr_reg[WAW-1:0]];
    end

    // Bias memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_word.req_type == REQ_BIAS
            && 32'(in_word.neuron_index) < 32'(MAX_NEURONS))
        begin
            bias_mem[in_word.neuron_index[NAW-1:0]] <= in_word.value;
        end
        bias_q <= bias_mem[ncnt_reg[NAW-1:0]];
    end

    // Pre-activation memory.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINAL)
        begin
            pre_mem[ncnt_reg[NAW-1:0]] <= p;
        end
        pre_q <= pre_mem[ncnt_reg[NAW-1:0]];
    end

    // Round half up to Q.12 and clamp to 32 bits.
    always_comb
    begin
        rounded     = (AW+1)'(acc_reg) + (AW+1)'(2048);
        shifted_acc = rounded >>> FRAC_BITS;
        if (shifted_acc > (AW+1)'(32'sh7fffffff))
        begin
            p = 32'sh7fffffff;
        end
        else if (shifted_acc < -(AW+1)'(33'sh080000000))
        begin
            p = 32'sh80000000;
        end
        else
        begin
            p = shifted_acc[PRE_WIDTH-1:0];
        end
    end

    // Exponential unit, shared by the sum pass and the output pass.
    assign ereq.start = ((state_reg == S_FINAL) && (mode_reg == ACT_SOFTMAX))
                        || (state_reg == S_OUT_LD);
    assign ereq.x = (state_reg == S_FINAL) ? p : pre_q;

    dlf_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ereq),
        .rsp   (ersp)
    );

    // Activation of one pre-activation value.
    always_comb
    begin
        leak = 40'((40'(x_reg) * 40'(LEAK_SLOPE) + 40'sd2048) >>> FRAC_BITS);
        case (mode_reg)
            ACT_RELU:
            begin
                v = x_reg[PRE_WIDTH-1] ? '0 : 41'(x_reg);
            end
            ACT_LEAKY:
            begin
                v = x_reg[PRE_WIDTH-1] ? 41'(leak) : 41'(x_reg);
            end
            ACT_ELU:
            begin
                v = x_reg[PRE_WIDTH-1] ? $signed({7'b0, e_reg}) - 41'sd4096 : 41'(x_reg);
            end
            ACT_SOFTMAX:
            begin
                v = $signed({7'b0, e_reg});
            end
            default:
            begin
                v = 41'(x_reg);
            end
        endcase
        if (v > 41'((41'sd1 <<< (DATA_WIDTH - 1)) - 41'sd1))
        begin
            v_clip = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            v_sat  = 1'b1;
        end
        else if (v < -(41'sd1 <<< (DATA_WIDTH - 1)))
        begin
            v_clip = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            v_sat  = 1'b1;
        end
        else
        begin
            v_clip = v[DATA_WIDTH-1:0];
            v_sat  = 1'b0;
        end
    end

    assign rem_shift = {rem_reg[SUM_WIDTH-1:0], num_reg[NUMW-1]};
    assign out_free = !out_valid_reg || out_word.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ACT_NONE;
            icount_reg <= 7'd64;
            ncount_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    mode_reg   <= cfg_data[2:0];
                CFG_INPUTS:  icount_reg <= cfg_data;
                CFG_NEURONS: ncount_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            icnt_reg      <= '0;
            ncnt_reg      <= '0;
            waddr_reg     <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            sum_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            // A new result word replaces the one that leaves in the same cycle.
            if (state_reg == S_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    ncnt_reg <= '0;
                    if (in_fire && in_word.req_type == REQ_INPUT && in_word.last_element
                        && nn != '0)
                    begin
                        sum_reg   <= '0;
                        state_reg <= S_BIAS_RD;
                    end
                end
                S_BIAS_RD:
                begin
                    icnt_reg  <= '0;
                    waddr_reg <= (WAW+1)'(ncnt_reg);
                    state_reg <= S_BIAS_LD;
                end
                S_BIAS_LD:
                begin
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (issue)
                    begin
                        icnt_reg  <= icnt_reg + ICW'(1);
                        waddr_reg <= waddr_reg + (WAW+1)'(MAX_NEURONS);
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !mul_v_reg)
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    if (mode_reg == ACT_SOFTMAX)
                    begin
                        state_reg <= S_SUM;
                    end
                    else if (last_n)
                    begin
                        ncnt_reg  <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        ncnt_reg  <= ncnt_reg + NCW'(1);
                        state_reg <= S_BIAS_RD;
                    end
                end
                S_SUM:
                begin
                    if (ersp.done)
                    begin
                        sum_reg <= sum_reg + SUM_WIDTH'(ersp.result);
                        if (last_n)
                        begin
                            ncnt_reg  <= '0;
                            state_reg <= S_OUT_RD;
                        end
                        else
                        begin
                            ncnt_reg  <= ncnt_reg + NCW'(1);
                            state_reg <= S_BIAS_RD;
                        end
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    state_reg <= S_OUT_EXP;
                end
                S_OUT_EXP:
                begin
                    if (ersp.done)
                    begin
                        if (mode_reg == ACT_SOFTMAX && sum_reg != '0)
                        begin
                            div_cnt_reg <= '0;
                            state_reg   <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_ACT;
                        end
                    end
                end
                S_ACT:
                begin
                    state_reg <= S_SEND;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'(NUMW - 1))
                    begin
                        state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        if (last_n)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ncnt_reg  <= ncnt_reg + NCW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= in_q * w_q;
        if (state_reg == S_BIAS_LD)
        begin
            acc_reg <= AW'(bias_q) <<< FRAC_BITS;
        end
        else if (mul_v_reg)
        begin
            acc_reg <= acc_reg + AW'(mul_reg);
        end
        if (state_reg == S_OUT_LD)
        begin
            x_reg <= pre_q;
        end
        if (state_reg == S_OUT_EXP && ersp.done)
        begin
            e_reg   <= ersp.result;
            num_reg <= NUMW'({ersp.result, 12'b0}) + NUMW'(sum_reg >> 1);
            rem_reg <= '0;
        end
        if (state_reg == S_ACT)
        begin
            a_reg   <= v_clip;
            sat_reg <= v_sat;
        end
        // Restoring division, one quotient bit per cycle.
        if (state_reg == S_DIV)
        begin
            num_reg <= num_reg << 1;
            if (rem_shift >= {1'b0, sum_reg})
            begin
                rem_reg <= rem_shift - {1'b0, sum_reg};
                quo_reg <= {quo_reg[NUMW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NUMW-2:0], 1'b0};
            end
            if (div_cnt_reg == 6'(NUMW - 1))
            begin
                if (rem_shift >= {1'b0, sum_reg})
                begin
                    a_reg <= $signed({quo_reg[DATA_WIDTH-2:0], 1'b1});
                end
                else
                begin
                    a_reg <= $signed({quo_reg[DATA_WIDTH-2:0], 1'b0});
                end
                sat_reg <= 1'b0;
            end
        end
        if (state_reg == S_SEND && out_free)
        begin
            out_neuron_reg <= 6'(ncnt_reg);
            out_act_reg    <= a_reg;
            out_sat_reg    <= sat_reg;
            out_last_reg   <= last_n;
        end
    end

    assign out_word.valid       = out_valid_reg;
    assign out_word.out_neuron  = out_neuron_reg;
    assign out_word.activation  = out_act_reg;
    assign out_word.saturated   = out_sat_reg;
    assign out_word.last_result = out_last_reg;

endmodule
